FILE: hw/rtl/rfms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfms_pkg: shared types and constants of the RSSI fingerprint match scorer
// Widths, command and result layouts, and the level-to-bin conversion.
// ----------------------------------------------------------------------------
package rfms_pkg;

    localparam int TABLE_DEPTH    = 128;
    localparam int NUM_BINS       = 20;
    localparam int MAX_CANDIDATES = 1024;

    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W     = 2;
    localparam int MAC_W    = 48;
    localparam int LEVEL_W  = 8;
    localparam int BIN_W    = 5;
    localparam int COUNT_W  = 16;
    localparam int SCORE_W  = 32;
    localparam int CAND_W   = 10;
    localparam int ENTRY_W  = MAC_W + BIN_W + 1;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 88;

    // Lowest and highest level (dBm) whose bin lies in range
    localparam int LEVEL_LO = -(NUM_BINS * 5 - 1);
    localparam int LEVEL_HI = 4;
    // Reciprocal of 5 in Q10, exact for magnitudes up to 128
    localparam int RECIP5   = 205;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ELEM  = 2'd1,
        OP_END   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic             ok;
        logic [BIN_W-1:0] bin;
    } bin_info_t;

    typedef struct packed {
        op_t                op;
        logic [MAC_W-1:0]   mac;
        logic [BIN_W-1:0]   bin;
        logic               bin_ok;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [BIN_W-1:0]   bin;
        logic [MAC_W-1:0]   mac;
    } entry_t;

    typedef struct packed {
        logic               overflow;
        logic               best_found;
        logic [SCORE_W-1:0] best_score;
        logic [CAND_W-1:0]  best_number;
        logic [SCORE_W-1:0] cand_score;
        logic [CAND_W-1:0]  cand_number;
    } result_t;

    function automatic bin_info_t level_to_bin(input logic signed [LEVEL_W-1:0] level);
        logic signed [LEVEL_W:0] lv;
        logic [LEVEL_W-1:0]      mag;
        logic [2*LEVEL_W-1:0]    prod;
        bin_info_t               info;
        lv       = LEVEL_W'(level) == level ? {level[LEVEL_W-1], level} : '0;
        mag      = (lv <= 0) ? LEVEL_W'(-lv) : '0;
        prod     = mag * LEVEL_W'(RECIP5);
        info.ok  = (lv <= (LEVEL_W+1)'(LEVEL_HI)) && (lv >= (LEVEL_W+1)'(LEVEL_LO));
        info.bin = BIN_W'(prod >> 10);
        return info;
    endfunction

endpackage

FILE: hw/rtl/rfms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfms_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/rfms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfms_front: input side of the scorer
// Accept items, convert load levels to bins, and queue commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rfms_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rfms_pkg::op_t                 in_op,
    input  logic [rfms_pkg::MAC_W-1:0]    in_mac,
    input  logic [rfms_pkg::LEVEL_W-1:0]  in_level,
    input  logic [rfms_pkg::BIN_W-1:0]    in_bin,
    input  logic [rfms_pkg::COUNT_W-1:0]  in_count,
    output logic                          cmd_valid,
    output rfms_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    rfms_pkg::cmd_t      q_mem_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          fill_reg, fill_next;
    rfms_pkg::cmd_t      cmd_in;
    rfms_pkg::bin_info_t info;
    logic                push;

    always_comb
    begin
        info          = rfms_pkg::level_to_bin(in_level);
        cmd_in.op     = in_op;
        cmd_in.mac    = in_mac;
        cmd_in.count  = in_count;
        if (in_op == rfms_pkg::OP_LOAD)
        begin
            cmd_in.bin    = info.bin;
            cmd_in.bin_ok = info.ok;
        end
        else
        begin
            cmd_in.bin    = in_bin;
            cmd_in.bin_ok = 1'b0;
        end
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: hw/rtl/rfms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfms_back: execution side of the scorer
// Store loads in the table, scan the table once per fingerprint element,
// keep score and best, and register results for the output channel.
// ----------------------------------------------------------------------------
module rfms_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  rfms_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rfms_pkg::result_t      result
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                         state_reg, state_next;
    logic [rfms_pkg::CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [rfms_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [rfms_pkg::SCORE_W-1:0]   score_reg, score_next;
    logic [rfms_pkg::SCORE_W-1:0]   best_score_reg, best_score_next;
    logic [rfms_pkg::CAND_W-1:0]    best_index_reg, best_index_next;
    logic                           best_found_reg, best_found_next;
    logic [rfms_pkg::CAND_W-1:0]    cand_reg, cand_next;
    logic                           overflow_reg, overflow_next;
    logic [rfms_pkg::MAC_W-1:0]     elem_mac_reg, elem_mac_next;
    logic [rfms_pkg::BIN_W-1:0]     elem_bin_reg, elem_bin_next;
    logic [rfms_pkg::COUNT_W-1:0]   elem_count_reg, elem_count_next;
    logic                           out_valid_reg, out_valid_next;
    rfms_pkg::result_t              result_reg, result_next;

    logic                           wr_en;
    logic                           rd_en;
    rfms_pkg::entry_t               wr_entry;
    logic [rfms_pkg::ENTRY_W-1:0]   rd_data;
    rfms_pkg::entry_t               rd_entry;
    logic                           hit;
    logic [rfms_pkg::SCORE_W:0]     sum;
    logic [rfms_pkg::SCORE_W-1:0]   score_sat;
    logic                           better;

    rfms_ram #(
        .WIDTH (rfms_pkg::ENTRY_W),
        .DEPTH (rfms_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_count_reg[rfms_pkg::ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[rfms_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign wr_entry.ok  = cmd.bin_ok;
    assign wr_entry.bin = cmd.bin;
    assign wr_entry.mac = cmd.mac;
    assign rd_entry     = rd_data;

    assign hit       = cmp_valid_reg && rd_entry.ok && (rd_entry.mac == elem_mac_reg)
                       && (rd_entry.bin == elem_bin_reg);
    assign sum       = {1'b0, score_reg} + {{(rfms_pkg::SCORE_W + 1 - rfms_pkg::COUNT_W){1'b0}},
                       elem_count_reg};
    assign score_sat = sum[rfms_pkg::SCORE_W] ? '1 : sum[rfms_pkg::SCORE_W-1:0];
    assign better    = (score_reg > best_score_reg);

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        idx_next         = idx_reg;
        cmp_valid_next   = 1'b0;
        score_next       = score_reg;
        best_score_next  = best_score_reg;
        best_index_next  = best_index_reg;
        best_found_next  = best_found_reg;
        cand_next        = cand_reg;
        overflow_next    = overflow_reg;
        elem_mac_next    = elem_mac_reg;
        elem_bin_next    = elem_bin_reg;
        elem_count_next  = elem_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        result_next      = result_reg;
        cmd_pop          = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        rfms_pkg::OP_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            if (entry_count_reg == rfms_pkg::CNT_W'(rfms_pkg::TABLE_DEPTH))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                entry_count_next = entry_count_reg + 1'b1;
                            end
                        end
                        rfms_pkg::OP_ELEM:
                        begin
                            cmd_pop         = 1'b1;
                            elem_mac_next   = cmd.mac;
                            elem_bin_next   = cmd.bin;
                            elem_count_next = cmd.count;
                            idx_next        = '0;
                            if (entry_count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        rfms_pkg::OP_END:
                        begin
                            if (!out_valid_reg || out_ready)
                            begin
                                cmd_pop                = 1'b1;
                                out_valid_next         = 1'b1;
                                result_next.cand_number = cand_reg;
                                result_next.cand_score  = score_reg;
                                result_next.overflow    = overflow_reg;
                                if (better)
                                begin
                                    best_score_next = score_reg;
                                    best_index_next = cand_reg;
                                    best_found_next = 1'b1;
                                    result_next.best_score  = score_reg;
                                    result_next.best_number = cand_reg;
                                    result_next.best_found  = 1'b1;
                                end
                                else
                                begin
                                    result_next.best_score  = best_score_reg;
                                    result_next.best_number = best_index_reg;
                                    result_next.best_found  = best_found_reg;
                                end
                                score_next = '0;
                                cand_next  = (cand_reg == rfms_pkg::CAND_W'(
                                              rfms_pkg::MAX_CANDIDATES - 1)) ? '0
                                              : cand_reg + 1'b1;
                            end
                        end
                        rfms_pkg::OP_CLEAR:
                        begin
                            cmd_pop          = 1'b1;
                            entry_count_next = '0;
                            score_next       = '0;
                            best_score_next  = '0;
                            best_index_next  = '0;
                            best_found_next  = 1'b0;
                            cand_next        = '0;
                            overflow_next    = 1'b0;
                        end
                        default:
                        begin
                            cmd_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (idx_reg != entry_count_reg)
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    score_next = score_sat;
                end
                if ((idx_reg == entry_count_reg) && !cmp_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            idx_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            score_reg       <= '0;
            best_score_reg  <= '0;
            best_index_reg  <= '0;
            best_found_reg  <= 1'b0;
            cand_reg        <= '0;
            overflow_reg    <= 1'b0;
            elem_mac_reg    <= '0;
            elem_bin_reg    <= '0;
            elem_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            idx_reg         <= idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            score_reg       <= score_next;
            best_score_reg  <= best_score_next;
            best_index_reg  <= best_index_next;
            best_found_reg  <= best_found_next;
            cand_reg        <= cand_next;
            overflow_reg    <= overflow_next;
            elem_mac_reg    <= elem_mac_next;
            elem_bin_reg    <= elem_bin_next;
            elem_count_reg  <= elem_count_next;
            out_valid_reg   <= out_valid_next;
            result_reg      <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (entry_count_reg != '0))
        else $error("scan running over an empty table");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (cmd_valid && (state_reg == ST_IDLE)))
        else $error("command popped from an empty queue or mid-scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= rfms_pkg::CNT_W'(rfms_pkg::TABLE_DEPTH))
        else $error("table fill count beyond depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_reg) |->
            ($past(entry_count_reg) == rfms_pkg::CNT_W'(rfms_pkg::TABLE_DEPTH)))
        else $error("overflow flagged with room left in the table");

    a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !best_found_reg |-> ((best_score_reg == '0) && (best_index_reg == '0)))
        else $error("best score held without a best candidate");

endmodule

FILE: hw/rtl/rssi_fingerprint_match_scorer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_fingerprint_match_scorer_unit: RSSI fingerprint match scorer, top level
// Load a table of observed access points, score candidate fingerprints
// against it, and report each candidate's score with the running best.
//
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: mac, level,
//                                             bin, count
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: candidate_number,
//                                             candidate_score, best_number,
//                                             best_score, best_found,
//                                             table_overflow
//
// Load, end candidate and clear are handled directly in the back end's idle state.
// A fingerprint element goes through an accept step, one table read per stored
// entry through the single read port, a final compare and an exit step.
// A two-entry queue lets the input side keep accepting during a scan.
// Besides waiting out a scan, an end candidate waits while an earlier result is still untaken.
// Reset is asynchronous, active low; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module rssi_fingerprint_match_scorer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mac[47:0], level[55:48], bin[60:56], count[76:61], zero[79:77]
    input  logic [rfms_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [rfms_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // candidate_number[9:0], candidate_score[41:10], best_number[51:42],
    // best_score[83:52], best_found[84], table_overflow[85], zero[87:86]
    output logic [rfms_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    logic              cmd_valid;
    logic              cmd_pop;
    rfms_pkg::cmd_t    cmd;
    rfms_pkg::result_t result;

    rfms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (rfms_pkg::op_t'(s_axis_tuser)),
        .in_mac    (s_axis_tdata[47:0]),
        .in_level  (s_axis_tdata[55:48]),
        .in_bin    (s_axis_tdata[60:56]),
        .in_count  (s_axis_tdata[76:61]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    rfms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {{(rfms_pkg::M_DATA_W - $bits(rfms_pkg::result_t)){1'b0}}, result};

endmodule

FILE: tb/sv/rssi_fingerprint_match_scorer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_fingerprint_match_scorer_unit_tb: self-checking bench for the scorer
// Streams access point loads, fingerprint elements, candidate ends and clears
// into the block under changing sender gaps and receiver stalls. A scoreboard
// mirrors the AP table and scores, predicts every candidate report, and
// compares each output item field by field in order of arrival.
// ----------------------------------------------------------------------------
module rssi_fingerprint_match_scorer_unit_tb;

    import rfms_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int TOTAL_ITEMS  = 1900;

    class score_tracker;
        logic [MAC_W-1:0]   tab_mac [TABLE_DEPTH];
        logic [BIN_W-1:0]   tab_bin [TABLE_DEPTH];
        bit                 tab_ok  [TABLE_DEPTH];
        int unsigned        entry_count;
        logic [SCORE_W-1:0] running_score;
        logic [SCORE_W-1:0] best_score;
        logic [CAND_W-1:0]  best_number;
        logic [CAND_W-1:0]  cand_number;
        bit                 best_found;
        bit                 overflow;
        result_t            reports_due [$];
        int                 errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            entry_count   = 0;
            running_score = '0;
            best_score    = '0;
            best_number   = '0;
            cand_number   = '0;
            best_found    = 1'b0;
            overflow      = 1'b0;
        endfunction

        function void note_item(input op_t op, input logic [MAC_W-1:0] mac,
                                input logic [LEVEL_W-1:0] level,
                                input logic [BIN_W-1:0] bin,
                                input logic [COUNT_W-1:0] count);
            int                 lvl;
            int                 q;
            logic [SCORE_W:0]   sum;
            result_t            r;
            case (op)
                OP_LOAD:
                begin
                    lvl = int'($signed(level));
                    q   = (-lvl) / 5;
                    if (entry_count >= TABLE_DEPTH)
                    begin
                        overflow = 1'b1;
                    end
                    else
                    begin
                        tab_mac[entry_count] = mac;
                        tab_ok[entry_count]  = (q >= 0) && (q < NUM_BINS);
                        tab_bin[entry_count] = tab_ok[entry_count] ? BIN_W'(q) : '0;
                        entry_count++;
                    end
                end
                OP_ELEM:
                begin
                    for (int j = 0; j < entry_count; j++)
                    begin
                        if (tab_ok[j] && tab_mac[j] == mac && tab_bin[j] == bin)
                        begin
                            sum = {1'b0, running_score} + (SCORE_W+1)'(count);
                            running_score = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                        end
                    end
                end
                OP_END:
                begin
                    if (running_score > best_score)
                    begin
                        best_score  = running_score;
                        best_number = cand_number;
                        best_found  = 1'b1;
                    end
                    r.cand_number = cand_number;
                    r.cand_score  = running_score;
                    r.best_number = best_number;
                    r.best_score  = best_score;
                    r.best_found  = best_found;
                    r.overflow    = overflow;
                    reports_due.push_back(r);
                    running_score = '0;
                    if (int'(cand_number) + 1 >= MAX_CANDIDATES)
                        cand_number = '0;
                    else
                        cand_number = cand_number + 1'b1;
                end
                default:
                begin
                    wipe();
                end
            endcase
        endfunction

        task report_mismatch(input string what, input logic [SCORE_W-1:0] exp_val,
                             input logic [SCORE_W-1:0] got_val);
            $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, got_val);
            errors++;
        endtask

        task compare_field(input string what, input logic [SCORE_W-1:0] exp_val,
                           input logic [SCORE_W-1:0] got_val);
            if (exp_val !== got_val)
                report_mismatch(what, exp_val, got_val);
        endtask

        task check_score(input logic [M_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[$bits(result_t)-1:0]);
            if (reports_due.size() == 0)
            begin
                report_mismatch("unexpected report, candidate_number", '0,
                                SCORE_W'(got.cand_number));
            end
            else
            begin
                want = reports_due.pop_front();
                compare_field("candidate_number", SCORE_W'(want.cand_number),
                              SCORE_W'(got.cand_number));
                compare_field("candidate_score", want.cand_score, got.cand_score);
                compare_field("best_number", SCORE_W'(want.best_number),
                              SCORE_W'(got.best_number));
                compare_field("best_score", want.best_score, got.best_score);
                compare_field("best_found", SCORE_W'(want.best_found),
                              SCORE_W'(got.best_found));
                compare_field("table_overflow", SCORE_W'(want.overflow),
                              SCORE_W'(got.overflow));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    score_tracker tracker;
    int           items_sent;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cycles;

    rssi_fingerprint_match_scorer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [LEVEL_W-1:0] dbm(input int v);
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return w[MAC_W-1:0];
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level();
        if ($urandom_range(9) < 7)
            return dbm(int'($urandom_range(104)) - 100);
        return LEVEL_W'($urandom_range(255));
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return COUNT_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_item(input op_t op, input logic [MAC_W-1:0] mac,
                             input logic [LEVEL_W-1:0] level,
                             input logic [BIN_W-1:0] bin,
                             input logic [COUNT_W-1:0] count);
        int phase;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-77){1'b0}}, count, bin, level, mac};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_item(op, mac, level, bin, count);
        items_sent++;
        phase = (items_sent / 97) % 4;
        send_idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 15 : 0;
        recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 15 : 0;
    endtask

    task automatic send_load();
        int               j;
        logic [MAC_W-1:0] mac;
        logic [LEVEL_W-1:0] level;
        mac   = rand_mac();
        level = rand_level();
        if (tracker.entry_count != 0 && $urandom_range(9) < 3)
        begin
            j = $urandom_range(tracker.entry_count - 1);
            if (tracker.tab_ok[j])
            begin
                mac   = tracker.tab_mac[j];
                level = dbm(-(int'(tracker.tab_bin[j]) * 5 + int'($urandom_range(4))));
            end
        end
        send_item(OP_LOAD, mac, level, BIN_W'($urandom_range(31)), rand_count());
    endtask

    task automatic send_element();
        int               j;
        int               pick;
        logic [MAC_W-1:0] mac;
        logic [BIN_W-1:0] bin;
        pick = $urandom_range(99);
        mac  = rand_mac();
        bin  = BIN_W'($urandom_range(31));
        if (tracker.entry_count != 0 && pick < 80)
        begin
            j   = $urandom_range(tracker.entry_count - 1);
            mac = tracker.tab_mac[j];
            if (pick < 65 && tracker.tab_ok[j])
                bin = tracker.tab_bin[j];
        end
        send_item(OP_ELEM, mac, rand_level(), bin, rand_count());
    endtask

    task automatic send_bare(input op_t op);
        send_item(op, rand_mac(), rand_level(), BIN_W'($urandom_range(31)), rand_count());
    endtask

    task automatic run_directed();
        logic [MAC_W-1:0] mac_a;
        logic [MAC_W-1:0] mac_b;
        logic [MAC_W-1:0] mac_c;
        logic [MAC_W-1:0] mac_d;
        logic [MAC_W-1:0] mac_e;
        mac_a = 48'h0000_0000_0001;
        mac_b = 48'h8000_0000_0000;
        mac_c = 48'hA5A5_5A5A_A5A5;
        mac_d = 48'h5A5A_A5A5_5A5A;
        mac_e = 48'h0123_4567_89AB;
        send_item(OP_END, '0, '0, '0, '0);
        send_item(OP_ELEM, mac_a, '0, 5'd0, 16'd5);
        send_item(OP_LOAD, '0, dbm(-128), '0, '0);
        send_item(OP_LOAD, '1, dbm(127), '1, '1);
        send_item(OP_LOAD, mac_a, dbm(3), '0, '0);
        send_item(OP_LOAD, mac_b, dbm(4), '0, '0);
        send_item(OP_LOAD, mac_c, dbm(5), '0, '0);
        send_item(OP_LOAD, mac_d, dbm(-99), '0, '0);
        send_item(OP_LOAD, mac_e, dbm(-100), '0, '0);
        send_item(OP_LOAD, mac_d, dbm(-95), '0, '0);
        send_item(OP_ELEM, '0, '0, 5'd25, '1);
        send_item(OP_ELEM, '1, '1, 5'd31, '1);
        send_item(OP_ELEM, mac_a, '0, 5'd0, '1);
        send_item(OP_ELEM, mac_b, '0, 5'd0, '0);
        send_item(OP_ELEM, mac_c, '0, 5'd0, 16'd100);
        send_item(OP_ELEM, mac_d, '0, 5'd19, 16'd1);
        send_item(OP_ELEM, mac_e, '0, 5'd20, 16'd7);
        send_item(OP_END, '0, '0, '0, '0);
        send_item(OP_END, '1, '1, '1, '1);
        send_item(OP_ELEM, mac_d, '0, 5'd19, 16'd40000);
        send_item(OP_END, '0, '0, '0, '0);
        send_item(OP_ELEM, mac_d, '0, 5'd19, 16'd40000);
        send_item(OP_END, '0, '0, '0, '0);
        send_item(OP_CLEAR, '1, '1, '1, '1);
        send_item(OP_END, '0, '0, '0, '0);
    endtask

    task automatic run_saturation();
        logic [MAC_W-1:0] mac;
        mac = rand_mac();
        send_bare(OP_CLEAR);
        repeat (TABLE_DEPTH + 2)
            send_item(OP_LOAD, mac, dbm(-50 - int'($urandom_range(4))), '0, '0);
        while (tracker.running_score != '1)
            send_item(OP_ELEM, mac, rand_level(), 5'd10,
                      COUNT_W'($urandom_range(65535, 60000)));
        repeat (4)
            send_item(OP_ELEM, mac, rand_level(), 5'd10, '1);
        send_bare(OP_END);
        send_bare(OP_END);
    endtask

    task automatic run_wrap();
        send_bare(OP_CLEAR);
        repeat (3)
            send_item(OP_LOAD, rand_mac(), dbm(-int'($urandom_range(99))), '0, '0);
        repeat (MAX_CANDIDATES + 8)
        begin
            if ($urandom_range(19) == 0)
                send_element();
            send_bare(OP_END);
        end
    endtask

    task automatic run_sequence();
        int n;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(6, 1))
            begin
                case (op_t'($urandom_range(3)))
                    OP_LOAD:  send_load();
                    OP_ELEM:  send_element();
                    OP_END:   send_bare(OP_END);
                    default:  send_bare(OP_CLEAR);
                endcase
            end
        end
        else
        begin
            if ($urandom_range(9) == 0)
                send_bare(OP_CLEAR);
            n = ($urandom_range(19) == 0) ? $urandom_range(135, 120) : $urandom_range(8);
            repeat (n)
                send_load();
            repeat ($urandom_range(3, 1))
            begin
                repeat ($urandom_range(6))
                    send_element();
                send_bare(OP_END);
            end
        end
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.check_score(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        tracker        = new();
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycles         = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_saturation();
        run_wrap();
        while (items_sent < TOTAL_ITEMS)
            run_sequence();

        s_axis_tvalid <= 1'b0;
        while (tracker.reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
